[rtl/core/gsd_pkg.sv]
// Shared constants, types and the 6-and-2 reverse table for the GCR sector decoder.
// Used by every rtl/core module but gsd_ram; depends on nothing.
package gsd_pkg;

	localparam int AUX_LEN      = 86;
	localparam int SECTOR_BYTES = 256;
	localparam int DATA_END     = AUX_LEN + SECTOR_BYTES;
	localparam int IDLE_POS     = DATA_END + 1;

	localparam int POS_W    = 9;
	localparam int AUX_AW   = 7;
	localparam int VAL_W    = 6;
	localparam int SEC_W    = 2;
	localparam int BYTE_W   = 8;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// section of the data field: which aux pair feeds the low two bits
	localparam logic [SEC_W-1:0] SEC_LOW  = 2'd0;
	localparam logic [SEC_W-1:0] SEC_MID  = 2'd1;
	localparam logic [SEC_W-1:0] SEC_HIGH = 2'd2;

	localparam logic [VAL_W-1:0] GCR_REV [128] = '{
		6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,
		6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,
		6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h01,
		6'h00,6'h00,6'h02,6'h03,6'h00,6'h04,6'h05,6'h06,
		6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h07,6'h08,
		6'h00,6'h00,6'h00,6'h09,6'h0a,6'h0b,6'h0c,6'h0d,
		6'h00,6'h00,6'h0e,6'h0f,6'h10,6'h11,6'h12,6'h13,
		6'h00,6'h14,6'h15,6'h16,6'h17,6'h18,6'h19,6'h1a,
		6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,
		6'h00,6'h00,6'h00,6'h1b,6'h00,6'h1c,6'h1d,6'h1e,
		6'h00,6'h00,6'h00,6'h1f,6'h00,6'h00,6'h20,6'h21,
		6'h00,6'h22,6'h23,6'h24,6'h25,6'h26,6'h27,6'h28,
		6'h00,6'h00,6'h00,6'h00,6'h00,6'h29,6'h2a,6'h2b,
		6'h00,6'h2c,6'h2d,6'h2e,6'h2f,6'h30,6'h31,6'h32,
		6'h00,6'h00,6'h33,6'h34,6'h35,6'h36,6'h37,6'h38,
		6'h00,6'h39,6'h3a,6'h3b,6'h3c,6'h3d,6'h3e,6'h3f
	};

	// front to back: one decoded data nibble awaiting its aux pair
	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [SEC_W-1:0]  section;
		logic [BYTE_W-1:0] byte_index;
		logic              last;
	} front_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_index;
		logic              last_byte;
	} result_t;

endpackage

[rtl/core/gsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/gsd_front.sv]
// Front end: table lookup, chain XOR, field position tracking, aux writes and reads.
// Depends on gsd_pkg; drives the aux RAM ports and the stage-1 item for gsd_back.
module gsd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [7:0]                 disk_nibble,
	input  logic                       begin_field,
	output logic                       aux_we,
	output logic [gsd_pkg::AUX_AW-1:0] aux_waddr,
	output logic [gsd_pkg::VAL_W-1:0]  aux_wdata,
	output logic                       aux_re,
	output logic [gsd_pkg::AUX_AW-1:0] aux_raddr,
	output logic                       item_valid_s1,
	output gsd_pkg::front_item_t       item_s1
);

	logic [gsd_pkg::POS_W-1:0]  pos_q, pos_e;
	logic [gsd_pkg::VAL_W-1:0]  chain_q, chain_e, value;
	logic [gsd_pkg::AUX_AW-1:0] idx_q, idx_e;
	logic [gsd_pkg::SEC_W-1:0]  sec_q, sec_e;
	logic                       live, is_aux, is_data, take;

	// begin_field restarts the field before this nibble is decoded
	assign pos_e   = begin_field ? '0 : pos_q;
	assign chain_e = begin_field ? '0 : chain_q;
	assign idx_e   = begin_field ? '0 : idx_q;
	assign sec_e   = begin_field ? gsd_pkg::SEC_LOW : sec_q;

	assign live    = pos_e < gsd_pkg::POS_W'(gsd_pkg::IDLE_POS);
	assign is_aux  = pos_e < gsd_pkg::POS_W'(gsd_pkg::AUX_LEN);
	assign is_data = !is_aux && (pos_e < gsd_pkg::POS_W'(gsd_pkg::DATA_END));
	assign take    = accept && live;
	assign value   = gsd_pkg::GCR_REV[disk_nibble[6:0]] ^ chain_e;

	assign aux_we    = take && is_aux;
	assign aux_waddr = pos_e[gsd_pkg::AUX_AW-1:0];
	assign aux_wdata = value;
	assign aux_re    = take && is_data;
	assign aux_raddr = idx_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			chain_q       <= '0;
			idx_q         <= '0;
			sec_q         <= gsd_pkg::SEC_LOW;
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= take && is_data;
			if (take) begin
				pos_q   <= pos_e + 1'b1;
				chain_q <= value;
				if (is_data) begin
					if (idx_e == gsd_pkg::AUX_AW'(gsd_pkg::AUX_LEN - 1)) begin
						idx_q <= '0;
						sec_q <= sec_e + 1'b1;
					end else begin
						idx_q <= idx_e + 1'b1;
						sec_q <= sec_e;
					end
				end else begin
					idx_q <= idx_e;
					sec_q <= sec_e;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_data) begin
			item_s1.value      <= value;
			item_s1.section    <= sec_e;
			item_s1.byte_index <= gsd_pkg::BYTE_W'(pos_e - gsd_pkg::POS_W'(gsd_pkg::AUX_LEN));
			item_s1.last       <= pos_e == gsd_pkg::POS_W'(gsd_pkg::DATA_END - 1);
		end
	end

endmodule

[rtl/core/gsd_back.sv]
// Back end: merges the aux pair into each data byte and queues results for the consumer.
// Depends on gsd_pkg; fed by gsd_front and the aux RAM read port.
module gsd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid_s1,
	input  gsd_pkg::front_item_t          item_s1,
	input  logic [gsd_pkg::VAL_W-1:0]     aux_rdata,
	input  logic                          pop,
	output logic                          empty,
	output logic                          room,
	output logic [gsd_pkg::FIFO_CW-1:0]   level,
	output gsd_pkg::result_t              head
);

	gsd_pkg::result_t               entry_q [gsd_pkg::FIFO_DEPTH];
	gsd_pkg::result_t               res;
	logic [gsd_pkg::FIFO_AW-1:0]    wr_q, rd_q;
	logic [gsd_pkg::FIFO_CW-1:0]    count_q;
	logic [1:0]                     pair;
	logic                           do_pop;

	// pair bits come out swapped
	always_comb begin
		case (item_s1.section)
			gsd_pkg::SEC_LOW: pair = {aux_rdata[0], aux_rdata[1]};
			gsd_pkg::SEC_MID: pair = {aux_rdata[2], aux_rdata[3]};
			default:          pair = {aux_rdata[4], aux_rdata[5]};
		endcase
	end

	assign res.data_byte  = {item_s1.value, pair};
	assign res.byte_index = item_s1.byte_index;
	assign res.last_byte  = item_s1.last;

	assign do_pop = pop && !empty;
	assign empty  = count_q == '0;
	assign level  = count_q;
	assign head   = entry_q[rd_q];
	// leave a slot for the item already in stage 1
	assign room   = (count_q + gsd_pkg::FIFO_CW'(item_valid_s1))
		< gsd_pkg::FIFO_CW'(gsd_pkg::FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (item_valid_s1) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + gsd_pkg::FIFO_CW'(item_valid_s1)
				- gsd_pkg::FIFO_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid_s1) begin
			entry_q[wr_q] <= res;
		end
	end

endmodule

[rtl/core/gcr_six_two_sector_decoder_unit.sv]
// GCR 6-and-2 data-field decoder: one disk byte per cycle in, one sector byte per data nibble out.
// A data nibble and its aux RAM read are registered in stage 1, then written to the result queue.
// Throughput: one nibble per cycle while results are popped at the same rate; the
// four-entry result queue lets input run on through short output stalls.
// Reset (arst_n low): position and chain cleared, result queue emptied; aux RAM not cleared.
// Depends on gsd_pkg, gsd_front, gsd_ram, gsd_back.
module gcr_six_two_sector_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] disk_nibble,
	input  logic       begin_field,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic       last_byte
);

	logic                        accept, room;
	logic                        aux_we, aux_re;
	logic [gsd_pkg::AUX_AW-1:0]  aux_waddr, aux_raddr;
	logic [gsd_pkg::VAL_W-1:0]   aux_wdata, aux_rdata;
	logic                        item_valid_s1;
	gsd_pkg::front_item_t        item_s1;
	gsd_pkg::result_t            head;
	logic [gsd_pkg::FIFO_CW-1:0] level;

	assign full   = !room;
	assign accept = push && !full;

	gsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.disk_nibble   (disk_nibble),
		.begin_field   (begin_field),
		.aux_we        (aux_we),
		.aux_waddr     (aux_waddr),
		.aux_wdata     (aux_wdata),
		.aux_re        (aux_re),
		.aux_raddr     (aux_raddr),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	gsd_ram #(
		.WIDTH (gsd_pkg::VAL_W),
		.DEPTH (gsd_pkg::AUX_LEN)
	) u_aux_ram (
		.clk   (clk),
		.we    (aux_we),
		.waddr (aux_waddr),
		.wdata (aux_wdata),
		.re    (aux_re),
		.raddr (aux_raddr),
		.rdata (aux_rdata)
	);

	gsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.aux_rdata     (aux_rdata),
		.pop           (pop),
		.empty         (empty),
		.room          (room),
		.level         (level),
		.head          (head)
	);

	assign data_byte  = head.data_byte;
	assign byte_index = head.byte_index;
	assign last_byte  = head.last_byte;

	// queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= gsd_pkg::FIFO_CW'(gsd_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	// a stage-1 item only follows a transfer in
	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 |-> $past(accept))
		else $error("stage-1 item without input transfer");

	// queue grows only through stage 1
	a_level_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(item_valid_s1) |-> level <= $past(level))
		else $error("queue level rose without a stage-1 item");

endmodule

[bench/tb_gcr_six_two_sector_decoder_unit.sv]
// Self-checking bench for the GCR 6-and-2 sector data-field decoder.
// Streams data fields in and checks each decoded sector byte against a built-in model.
// Depends on gsd_pkg and gcr_six_two_sector_decoder_unit.
`timescale 1ns / 1ps

module tb_gcr_six_two_sector_decoder_unit;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	// valid 6-and-2 disk codes in ascending order; position is the decoded value
	localparam logic [7:0] SIX_TWO_CODE [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] disk_nibble = 8'h00;
	logic       begin_field = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic       last_byte;

	// model state
	logic [gsd_pkg::VAL_W-1:0] aux_pairs [gsd_pkg::AUX_LEN];
	logic [gsd_pkg::VAL_W-1:0] chain_val = '0;
	int                        nibble_pos = 0;
	gsd_pkg::result_t          sector_bytes_due [$];

	int  mismatches = 0;
	int  bytes_checked = 0;
	int  nibbles_sent = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	int  rx_hold = 0;
	bit  rx_steady = 1'b0;

	gcr_six_two_sector_decoder_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.disk_nibble(disk_nibble),
		.begin_field(begin_field),
		.empty      (empty),
		.pop        (pop),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [gsd_pkg::VAL_W-1:0] reverse_code(input logic [6:0] idx);
		for (int v = 0; v < 64; v++) begin
			if (SIX_TWO_CODE[v][6:0] == idx)
				return v[gsd_pkg::VAL_W-1:0];
		end
		return '0;
	endfunction

	// advance the model by one transferred nibble, queueing any sector byte it yields
	task automatic decode_disk_nibble(input logic [7:0] nib, input logic beg);
		logic [gsd_pkg::VAL_W-1:0] value;
		logic [gsd_pkg::VAL_W-1:0] aux;
		logic [1:0]                low2;
		gsd_pkg::result_t          res;
		int                        p;
		int                        i;
		if (beg) begin
			nibble_pos = 0;
			chain_val = '0;
		end
		if (nibble_pos >= gsd_pkg::IDLE_POS)
			return;
		value = reverse_code(nib[6:0]) ^ chain_val;
		chain_val = value;
		p = nibble_pos;
		nibble_pos++;
		if (p < gsd_pkg::AUX_LEN) begin
			aux_pairs[p] = value;
		end else if (p < gsd_pkg::DATA_END) begin
			i = p - gsd_pkg::AUX_LEN;
			aux = aux_pairs[i % gsd_pkg::AUX_LEN];
			// pair comes out bit-swapped
			case (gsd_pkg::SEC_W'(i / gsd_pkg::AUX_LEN))
				gsd_pkg::SEC_LOW:  low2 = {aux[0], aux[1]};
				gsd_pkg::SEC_MID:  low2 = {aux[2], aux[3]};
				default:           low2 = {aux[4], aux[5]};
			endcase
			res.data_byte  = {value, low2};
			res.byte_index = i[7:0];
			res.last_byte  = (i == gsd_pkg::SECTOR_BYTES - 1);
			sector_bytes_due.push_back(res);
		end
	endtask

	// mostly valid codes steering to a chosen value, some with bit 7 cleared, some noise
	function automatic logic [7:0] pick_nibble(input logic [gsd_pkg::VAL_W-1:0] from_chain);
		logic [gsd_pkg::VAL_W-1:0] target;
		logic [7:0]                code;
		case ($urandom_range(0, 15))
			0: return 8'($urandom_range(0, 255));
			1: target = '0;
			2: target = '1;
			default: target = gsd_pkg::VAL_W'($urandom_range(0, 63));
		endcase
		code = SIX_TWO_CODE[target ^ from_chain];
		if ($urandom_range(0, 7) == 0)
			code[7] = 1'b0;
		return code;
	endfunction

	task automatic send_nibble(input logic [7:0] nib, input logic beg);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk) push = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
				: $urandom_range(1, 24);
		end
		@(negedge clk);
		push = 1'b1;
		disk_nibble = nib;
		begin_field = beg;
		@(posedge clk);
		while (full) @(posedge clk);
		decode_disk_nibble(nib, beg);
		nibbles_sent++;
		burst_left--;
	endtask

	task automatic send_field_nibble(input logic beg);
		send_nibble(pick_nibble(beg ? '0 : chain_val), beg);
	endtask

	task automatic wait_drained();
		@(negedge clk) push = 1'b0;
		burst_left = 0;
		while (sector_bytes_due.size() != 0) @(posedge clk);
	endtask

	// first field straight after reset, no begin flag; awkward and invalid bytes up front
	task automatic test_reset_start();
		logic [7:0] opening [20] = '{
			8'h00, 8'hff, 8'h7f, 8'h80, 8'h96, 8'h16, 8'haa, 8'h2a, 8'hd5, 8'h55,
			8'hfe, 8'h01, 8'h97, 8'he7, 8'h67, 8'hb5, 8'hc3, 8'h3c, 8'heb, 8'h6b
		};
		foreach (opening[k])
			send_nibble(opening[k], 1'b0);
	endtask

	// rest of that field, receiver held off once data nibbles start, then the checksum
	task automatic test_full_field();
		for (int p = 20; p < gsd_pkg::DATA_END; p++) begin
			if (p == gsd_pkg::AUX_LEN)
				rx_hold = 90;
			send_field_nibble(1'b0);
		end
		send_nibble(8'($urandom_range(0, 255)), 1'b0);
		wait_drained();
	endtask

	// past the checksum, nibbles without a begin flag are dropped
	task automatic test_idle_nibbles();
		repeat (6)
			send_nibble(8'($urandom_range(0, 255)), 1'b0);
		wait_drained();
	endtask

	// fields cut short by a fresh begin flag, then loose noise
	task automatic test_cut_fields();
		int data_count;
		int aux_count;
		data_count = $urandom_range(20, 60);
		aux_count = $urandom_range(5, 40);
		send_field_nibble(1'b1);
		repeat (gsd_pkg::AUX_LEN - 1 + data_count)
			send_field_nibble(1'b0);
		send_field_nibble(1'b1);
		repeat (aux_count)
			send_field_nibble(1'b0);
		repeat (12)
			send_nibble(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	// receiver: long hold-off on request, steady popping when rx_steady is set, otherwise a randomly redrawn stall pattern
	logic [7:0] rx_pattern = 8'hff;
	int         rx_tick = 0;
	always @(negedge clk) begin
		if (rx_tick % 50 == 0)
			rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255));
		if (rx_hold > 0) begin
			pop = 1'b0;
			rx_hold--;
		end else if (rx_steady) begin
			pop = 1'b1;
		end else begin
			pop = rx_pattern[rx_tick % 8];
		end
		rx_tick++;
	end

	always @(posedge clk) begin
		gsd_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (sector_bytes_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected byte: data %h index %0d last %b",
						data_byte, byte_index, last_byte);
				mismatches++;
			end else begin
				want = sector_bytes_due.pop_front();
				if (data_byte !== want.data_byte || byte_index !== want.byte_index ||
					last_byte !== want.last_byte) begin
					if (mismatches < MAX_REPORTS)
						$display("mismatch: want data %h index %0d last %b, got %h %0d %b",
							want.data_byte, want.byte_index, want.last_byte,
							data_byte, byte_index, last_byte);
					mismatches++;
				end
				bytes_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding",
				cycle_count, sector_bytes_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_reset_start();
		test_full_field();
		test_idle_nibbles();
		test_cut_fields();
		rx_steady = 1'b1;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d nibbles transferred, %0d sector bytes checked, %0d mismatches",
			nibbles_sent, bytes_checked, mismatches);
		$display("covered: start from reset, full field with checksum, idle nibbles, cut fields");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
